### design/lmbs_pkg.sv
// Shared types and constants for the LED matrix bit-plane scanner.
`timescale 1ns / 1ps
`default_nettype none
package lmbs_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = 10;
  localparam int PIX_W       = 6;
  localparam int ROW_W       = 3;
  localparam int PLANE_W     = 3;
  localparam int COL_W       = 6;
  localparam int PERIOD_W    = 24;
  localparam int DELAY_W     = 16;
  localparam int PADDR_W     = 3;

  localparam logic                OP_TICK          = 1'b0;
  localparam logic                OP_WRITE         = 1'b1;
  localparam logic                REG_BASE_DELAY   = 1'b0;
  localparam logic [DELAY_W-1:0]  BASE_DELAY_RESET = 16'd10;

  typedef struct packed {
    logic             use_pins;
    logic             shift_clock;
    logic             latch;
    logic             blank;
    logic [ROW_W-1:0] row_address;
  } tick_result_t;

endpackage
`default_nettype wire

### design/lmbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lmbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### design/led_matrix_bcm_scanner.sv
// Top level of the LED matrix binary code modulation scanner.
// A word is accepted per cycle, writes and ticks alike, while no clearing pass runs and the result stages can advance.
// A tick's result word is registered in the s1 stage and then in the output register.
// The ready path passes combinationally from m_tready to s_tready through two result stages.
// Reset is synchronous; it clears the control state and then runs a clearing pass over all 1024
// frame store entries, during which s_tready is low; register writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none
module led_matrix_bcm_scanner #(
  parameter int ROW_COUNT    = 8,
  parameter int PLANE_COUNT  = 4,
  parameter int COLUMN_COUNT = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [15:0]                   s_tdata,  // write_address[9:0], write_data[15:10]
  input  wire logic                          s_tuser,  // op
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [15:0]                   m_tdata,  // colour_pins[5:0], shift_clock[6],
                                                       // latch[7], blank[8], row_address[11:9]
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lmbs_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);
  import lmbs_pkg::*;

  logic [DELAY_W-1:0]  base_delay;
  logic                clearing;
  logic [ADDR_W-1:0]   clear_addr;

  logic [ROW_W-1:0]    shown_row, shown_row_next;
  logic [PLANE_W-1:0]  shown_plane, shown_plane_next;
  logic [ADDR_W-1:0]   read_pointer, read_pointer_next;
  logic [COL_W-1:0]    column_count, column_count_next;
  logic                clock_phase, clock_phase_next;
  logic [PERIOD_W-1:0] period_count, period_count_next;
  logic                latch_pending, latch_pending_next;
  logic                panel_lit, panel_lit_next;

  logic                s1_valid;
  tick_result_t        s1, s1_next;
  logic                o_valid;
  logic [15:0]         o_data;
  logic                advance;
  logic                accept, tick_acc, write_acc;
  logic                latch_now;

  logic [ROW_W-1:0]    load_row, succ_row;
  logic [PLANE_W-1:0]  load_plane, succ_plane;
  logic [ROW_W:0]      load_row_inc, succ_row_inc;
  logic [PLANE_W:0]    load_plane_inc, succ_plane_inc;
  logic [COL_W:0]      column_inc;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [PIX_W-1:0]    ram_wdata, ram_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BASE_DELAY) ? 32'(base_delay) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay <= BASE_DELAY_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BASE_DELAY)) begin
      base_delay <= pwdata[DELAY_W-1:0];
    end
  end

  assign advance   = !o_valid || m_tready;
  assign s_tready  = !clearing && (!s1_valid || advance);
  assign accept    = s_tvalid && s_tready;
  assign tick_acc  = accept && (s_tuser == OP_TICK);
  assign write_acc = accept && (s_tuser == OP_WRITE);
  assign latch_now = latch_pending && (period_count == '0);

  always_comb begin
    load_row       = '0;
    load_plane     = '0;
    load_plane_inc = {1'b0, shown_plane} + 1'b1;
    load_row_inc   = {1'b0, shown_row} + 1'b1;
    if (panel_lit) begin
      load_row   = shown_row;
      load_plane = load_plane_inc[PLANE_W-1:0];
      if (load_plane_inc >= (PLANE_W+1)'(PLANE_COUNT)) begin
        load_plane = '0;
        load_row   = load_row_inc[ROW_W-1:0];
        if (load_row_inc >= (ROW_W+1)'(ROW_COUNT)) begin
          load_row = '0;
        end
      end
    end
    succ_plane_inc = {1'b0, load_plane} + 1'b1;
    succ_row_inc   = {1'b0, load_row} + 1'b1;
    succ_row       = load_row;
    succ_plane     = succ_plane_inc[PLANE_W-1:0];
    if (succ_plane_inc >= (PLANE_W+1)'(PLANE_COUNT)) begin
      succ_plane = '0;
      succ_row   = succ_row_inc[ROW_W-1:0];
      if (succ_row_inc >= (ROW_W+1)'(ROW_COUNT)) begin
        succ_row = '0;
      end
    end
  end

  always_comb begin
    shown_row_next     = shown_row;
    shown_plane_next   = shown_plane;
    read_pointer_next  = read_pointer;
    column_count_next  = column_count;
    clock_phase_next   = clock_phase;
    period_count_next  = period_count;
    latch_pending_next = latch_pending;
    panel_lit_next     = panel_lit;
    column_inc         = {1'b0, column_count} + 1'b1;
    s1_next            = '0;
    ram_re             = 1'b0;
    if (latch_now) begin
      shown_row_next     = load_row;
      shown_plane_next   = load_plane;
      panel_lit_next     = 1'b1;
      latch_pending_next = 1'b0;
      period_count_next  = PERIOD_W'(base_delay) << load_plane;
      if (succ_row == '0 && succ_plane == '0) begin
        read_pointer_next = '0;
      end
      s1_next.latch       = 1'b1;
      s1_next.blank       = 1'b1;
      s1_next.row_address = load_row;
    end else begin
      if (period_count != '0) begin
        period_count_next = period_count - 1'b1;
      end
      if (!latch_pending) begin
        ram_re              = tick_acc;
        s1_next.use_pins    = 1'b1;
        s1_next.shift_clock = clock_phase;
        if (clock_phase) begin
          read_pointer_next = read_pointer + 1'b1;
          if (column_inc >= (COL_W+1)'(COLUMN_COUNT)) begin
            column_count_next  = '0;
            latch_pending_next = 1'b1;
          end else begin
            column_count_next = column_inc[COL_W-1:0];
          end
        end
        clock_phase_next = !clock_phase;
      end
      s1_next.blank       = !panel_lit;
      s1_next.row_address = shown_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shown_row     <= '0;
      shown_plane   <= '0;
      read_pointer  <= '0;
      column_count  <= '0;
      clock_phase   <= 1'b0;
      period_count  <= '0;
      latch_pending <= 1'b0;
      panel_lit     <= 1'b0;
    end else if (tick_acc) begin
      shown_row     <= shown_row_next;
      shown_plane   <= shown_plane_next;
      read_pointer  <= read_pointer_next;
      column_count  <= column_count_next;
      clock_phase   <= clock_phase_next;
      period_count  <= period_count_next;
      latch_pending <= latch_pending_next;
      panel_lit     <= panel_lit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == ADDR_W'(STORE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign ram_we    = clearing || write_acc;
  assign ram_waddr = clearing ? clear_addr : s_tdata[ADDR_W-1:0];
  assign ram_wdata = clearing ? '0 : s_tdata[ADDR_W +: PIX_W];

  lmbs_ram #(
    .WIDTH(PIX_W),
    .DEPTH(STORE_DEPTH)
  ) u_frame_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(read_pointer),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (tick_acc) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        o_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s1 <= s1_next;
    end
    if (advance && s1_valid) begin
      o_data <= {4'd0, s1.row_address, s1.blank, s1.latch, s1.shift_clock,
                 s1.use_pins ? ram_rdata : {PIX_W{1'b0}}};
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = o_data;

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("input accepted during frame store clearing pass");

  a_latch_blanks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[7]) |-> (m_tdata[8] && !m_tdata[6] && m_tdata[5:0] == '0))
    else $error("latch word without blanking or with live column data");

  a_phase_low_when_pending: assert property (@(posedge clk) disable iff (rst)
    latch_pending |-> !clock_phase)
    else $error("shift clock phase high while group shift is complete");

  a_latch_clears_pending: assert property (@(posedge clk) disable iff (rst)
    (tick_acc && latch_now) |=> (!latch_pending && panel_lit))
    else $error("latch tick did not start a new group");

endmodule
`default_nettype wire

### dv/led_matrix_bcm_checker.sv
// Checker that predicts the scanner's pin vectors and compares them with the result stream.
`timescale 1ns / 1ps
module led_matrix_bcm_checker #(
  parameter int ROW_COUNT    = 8,
  parameter int PLANE_COUNT  = 4,
  parameter int COLUMN_COUNT = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [15:0]                  s_tdata,  // write_address[9:0], write_data[15:10]
  input  logic                         s_tuser,  // op
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [15:0]                  m_tdata,  // colour_pins[5:0], shift_clock[6],
                                                 // latch[7], blank[8], row_address[11:9]
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [lmbs_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output int                           fail_count,
  output int                           words_pending,
  output int                           latches_seen,
  output int                           frames_started
);
  import lmbs_pkg::*;

  localparam logic [PADDR_W-1:0] BASE_DELAY_ADDR = PADDR_W'(REG_BASE_DELAY) << 2;

  typedef struct packed {
    logic [ROW_W-1:0] row_address;
    logic             blank;
    logic             latch;
    logic             shift_clock;
    logic [PIX_W-1:0] colour_pins;
  } pin_vector_t;

  logic [PIX_W-1:0]    frame_mem [STORE_DEPTH];
  logic [DELAY_W-1:0]  base_delay;
  logic [ROW_W-1:0]    shown_row;
  logic [PLANE_W-1:0]  shown_plane;
  logic [ADDR_W-1:0]   rd_ptr;
  logic [COL_W-1:0]    col_cnt;
  logic                clk_phase;
  logic [PERIOD_W-1:0] period_cnt;
  logic                latch_pend;
  logic                panel_lit;

  pin_vector_t pin_vectors_due[$];
  int          fails;
  int          latches;
  int          frames;

  // The group being shifted follows the shown one; before the first latch it is row 0, plane 0.
  function automatic void group_after_shown(output logic [ROW_W-1:0] row,
                                            output logic [PLANE_W-1:0] plane);
    int nr;
    int np;
    nr = 0;
    np = 0;
    if (panel_lit) begin
      nr = shown_row;
      np = shown_plane + 1;
      if (np >= PLANE_COUNT) begin
        np = 0;
        nr = nr + 1;
        if (nr >= ROW_COUNT) begin
          nr = 0;
        end
      end
    end
    row   = ROW_W'(nr);
    plane = PLANE_W'(np);
  endfunction

  function automatic pin_vector_t advance_scan();
    pin_vector_t v;
    logic [ROW_W-1:0]   r;
    logic [PLANE_W-1:0] p;
    v = '0;
    if (latch_pend && period_cnt == '0) begin
      group_after_shown(r, p);
      shown_row   = r;
      shown_plane = p;
      panel_lit   = 1'b1;
      latch_pend  = 1'b0;
      period_cnt  = PERIOD_W'(base_delay) << shown_plane;
      group_after_shown(r, p);
      if (r == '0 && p == '0) begin
        rd_ptr = '0;
        frames++;
      end
      v.latch       = 1'b1;
      v.blank       = 1'b1;
      v.row_address = shown_row;
    end else begin
      if (period_cnt != '0) begin
        period_cnt = period_cnt - 1'b1;
      end
      if (!latch_pend) begin
        v.colour_pins = frame_mem[rd_ptr];
        v.shift_clock = clk_phase;
        if (clk_phase) begin
          rd_ptr = rd_ptr + 1'b1;
          if (int'(col_cnt) + 1 >= COLUMN_COUNT) begin
            col_cnt    = '0;
            latch_pend = 1'b1;
          end else begin
            col_cnt = col_cnt + 1'b1;
          end
        end
        clk_phase = ~clk_phase;
      end
      v.blank       = ~panel_lit;
      v.row_address = shown_row;
    end
    return v;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : monitor
    pin_vector_t want;
    pin_vector_t got;
    if (rst) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        frame_mem[i] = '0;
      end
      base_delay  = BASE_DELAY_RESET;
      shown_row   = '0;
      shown_plane = '0;
      rd_ptr      = '0;
      col_cnt     = '0;
      clk_phase   = 1'b0;
      period_cnt  = '0;
      latch_pend  = 1'b0;
      panel_lit   = 1'b0;
      pin_vectors_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == BASE_DELAY_ADDR) begin
        base_delay = pwdata[DELAY_W-1:0];
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == OP_WRITE) begin
          frame_mem[s_tdata[ADDR_W-1:0]] = s_tdata[ADDR_W +: PIX_W];
        end else begin
          pin_vectors_due.push_back(advance_scan());
        end
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(pin_vector_t)-1:0];
        check_field("tdata padding", 0, int'(m_tdata[15:$bits(pin_vector_t)]));
        if (pin_vectors_due.size() == 0) begin
          $error("pin vector word %h arrived with none expected", m_tdata);
          fails++;
        end else begin
          want = pin_vectors_due.pop_front();
          check_field("colour_pins", want.colour_pins, got.colour_pins);
          check_field("shift_clock", want.shift_clock, got.shift_clock);
          check_field("latch", want.latch, got.latch);
          check_field("blank", want.blank, got.blank);
          check_field("row_address", want.row_address, got.row_address);
        end
        if (got.latch) begin
          latches++;
        end
      end
    end
    fail_count     <= fails;
    words_pending  <= pin_vectors_due.size();
    latches_seen   <= latches;
    frames_started <= frames;
  end

endmodule

### dv/tb_led_matrix_bcm_scanner.sv
// Testbench top for the LED matrix scanner: stimulus, handshake pacing and the final verdict.
`timescale 1ns / 1ps
module tb_led_matrix_bcm_scanner;
  import lmbs_pkg::*;

  localparam int ROWS         = 8;
  localparam int PLANES       = 4;
  localparam int COLS         = 32;
  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 4;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic [PADDR_W-1:0] BASE_DELAY_ADDR = PADDR_W'(REG_BASE_DELAY) << 2;

  logic               clk;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [15:0]        s_tdata  = '0;
  logic               s_tuser  = OP_TICK;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [15:0]        m_tdata;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [31:0]        pwdata   = '0;
  logic [31:0]        prdata;
  logic               pready;

  int send_idle_pct;
  int recv_idle_pct;
  int ticks_sent;
  int writes_sent;
  int delays_written;
  int cycle_count;
  int fail_count;
  int words_pending;
  int latches_seen;
  int frames_started;

  led_matrix_bcm_scanner #(
    .ROW_COUNT(ROWS), .PLANE_COUNT(PLANES), .COLUMN_COUNT(COLS)
  ) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  led_matrix_bcm_checker #(
    .ROW_COUNT(ROWS), .PLANE_COUNT(PLANES), .COLUMN_COUNT(COLS)
  ) scan_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .words_pending(words_pending),
    .latches_seen(latches_seen), .frames_started(frames_started)
  );

  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out with %0d pin vectors still expected.", words_pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic offer_word(input logic op, input logic [ADDR_W-1:0] addr,
                            input logic [PIX_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {data, addr};
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    if (op == OP_WRITE) begin
      writes_sent++;
    end else begin
      ticks_sent++;
    end
  endtask

  task automatic random_words(input int count, input int write_pct);
    for (int i = 0; i < count; i++) begin
      offer_word(($urandom_range(99) < write_pct) ? OP_WRITE : OP_TICK,
                 ADDR_W'($urandom_range(STORE_DEPTH - 1)), PIX_W'($urandom_range(63)));
    end
  endtask

  // Holds the input off until every expected pin vector is out and any write has settled.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_base_delay(input logic [DELAY_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BASE_DELAY_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    delays_written++;
  endtask

  task automatic start_phase(input logic [DELAY_W-1:0] delay, input int send_pct,
                             input int recv_pct);
    drain();
    set_base_delay(delay);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin : stimulus
    int group_base;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 26;
    recv_idle_pct = 62;

    // Directed opening under the reset delay: store extremes, then the unlit start of the scan.
    offer_word(OP_WRITE, ADDR_W'(0), PIX_W'(63));
    offer_word(OP_WRITE, ADDR_W'(STORE_DEPTH - 1), PIX_W'(63));
    offer_word(OP_WRITE, ADDR_W'(10'h2AA), PIX_W'(6'h2A));
    offer_word(OP_WRITE, ADDR_W'(10'h155), PIX_W'(6'h15));
    offer_word(OP_WRITE, ADDR_W'(1), PIX_W'(0));
    offer_word(OP_WRITE, ADDR_W'(2), PIX_W'(6'h21));
    offer_word(OP_TICK, '1, '1);
    for (int i = 0; i < 17; i++) begin
      offer_word(OP_TICK, '0, '0);
    end
    offer_word(OP_WRITE, ADDR_W'(9), PIX_W'(6'h3C));

    start_phase(DELAY_W'(1), 26, 62);
    random_words(200, 20);

    start_phase(DELAY_W'($urandom_range(20, 2)), 62, 26);
    random_words(200, 20);

    // Zero delay, so every latch follows the end of a shift.
    start_phase('0, 0, 0);
    group_base = $urandom_range(STORE_DEPTH - 2 * COLS);
    for (int i = 0; i < 2 * COLS; i++) begin
      offer_word(OP_WRITE, ADDR_W'(group_base + i), PIX_W'($urandom_range(63)));
    end
    random_words(200, 3);

    start_phase(BASE_DELAY_RESET, 0, 0);
    random_words(60, 20);

    start_phase('1, 0, 0);
    random_words(100, 20);

    drain();
    $display("Sent %0d ticks and %0d store writes across %0d base delay settings.",
             ticks_sent, writes_sent, delays_written);
    $display("Saw %0d latches; the scan started %0d new frames.", latches_seen, frames_started);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches found.", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
